// ----- rtl/cubic_bezier_evaluator_core_defines.svh -----
// Assertion macros used by the RTL of the cubic Bezier evaluator.
`ifndef CUBIC_BEZIER_EVALUATOR_CORE_DEFINES_SVH
`define CUBIC_BEZIER_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define CBE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define CBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cbe_pkg.sv -----
`default_nettype none

package cbe_pkg;

    // Default geometry
    localparam int COORD_WIDTH_DEF = 24;
    localparam int T_FRAC_BITS_DEF = 16;

    // Pipeline stages
    localparam int NUM_STAGES = 7;
    localparam int STG_IN     = 0;  // clamped t
    localparam int STG_A3U    = 1;  // a3 * t
    localparam int STG_H2     = 2;  // first Horner step, second derivative done
    localparam int STG_P2     = 3;  // partial products of second Horner step
    localparam int STG_H1     = 4;  // second Horner step, first derivative done
    localparam int STG_P1     = 5;  // partial products of last Horner step
    localparam int STG_OUT    = 6;  // curve point done

    // Configuration register map
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_SEL_WIDTH   = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NUM_REGS = CFG_INDEX_WIDTH'(8);
    localparam logic [CFG_SEL_WIDTH-1:0] REG_P0_X = 3'd0;
    localparam logic [CFG_SEL_WIDTH-1:0] REG_P0_Y = 3'd1;
    localparam logic [CFG_SEL_WIDTH-1:0] REG_P1_X = 3'd2;
    localparam logic [CFG_SEL_WIDTH-1:0] REG_P1_Y = 3'd3;
    localparam logic [CFG_SEL_WIDTH-1:0] REG_P2_X = 3'd4;
    localparam logic [CFG_SEL_WIDTH-1:0] REG_P2_Y = 3'd5;
    localparam logic [CFG_SEL_WIDTH-1:0] REG_P3_X = 3'd6;
    localparam logic [CFG_SEL_WIDTH-1:0] REG_P3_Y = 3'd7;

    // Pipeline control from the sequencer to the datapath
    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;  // stage register loads this cycle
        logic [NUM_STAGES-1:0] vld;  // stage register holds an item
    } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/cbe_coef.sv -----
`default_nettype none

// Power-basis coefficients of one axis from its four control points.
module cbe_coef #(
    parameter int COORD_WIDTH = cbe_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic signed [COORD_WIDTH-1:0]   q0,
    input  wire logic signed [COORD_WIDTH-1:0]   q1,
    input  wire logic signed [COORD_WIDTH-1:0]   q2,
    input  wire logic signed [COORD_WIDTH-1:0]   q3,
    output logic signed [COORD_WIDTH+4:0]        a0,
    output logic signed [COORD_WIDTH+4:0]        a1,
    output logic signed [COORD_WIDTH+4:0]        a2,
    output logic signed [COORD_WIDTH+4:0]        a3
);

    localparam int CFW = COORD_WIDTH + 5;

    logic signed [CFW-1:0] e0, e1, e2, e3;
    logic signed [CFW-1:0] a0_reg, a1_reg, a2_reg, a3_reg;
    logic signed [CFW-1:0] a0_next, a1_next, a2_next, a3_next;

    // Extend the points and form the coefficients
    always_comb
    begin
        e0 = CFW'(q0);
        e1 = CFW'(q1);
        e2 = CFW'(q2);
        e3 = CFW'(q3);
        a0_next = e0;
        a1_next = CFW'(3 * (e1 - e0));
        a2_next = CFW'(3 * (e0 - 2 * e1 + e2));
        a3_next = CFW'(e3 - e0 + 3 * (e1 - e2));
    end

    // Refresh every cycle; user must change points only in empty pipeline
    always_ff @(posedge clk)
    begin
        a0_reg <= a0_next;
        a1_reg <= a1_next;
        a2_reg <= a2_next;
        a3_reg <= a3_next;
    end

    assign a0 = a0_reg;
    assign a1 = a1_reg;
    assign a2 = a2_reg;
    assign a3 = a3_reg;

endmodule

`default_nettype wire

// ----- rtl/cbe_axis.sv -----
`default_nettype none

// Horner evaluation of one axis: point, first and second derivative.
module cbe_axis #(
    parameter int COORD_WIDTH = cbe_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = cbe_pkg::T_FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic [cbe_pkg::NUM_STAGES-1:0]    adv,
    input  wire logic [T_FRAC_BITS:0]              u_s0,
    input  wire logic [T_FRAC_BITS:0]              u_s2,
    input  wire logic [T_FRAC_BITS:0]              u_s4,
    input  wire logic signed [COORD_WIDTH+4:0]     a0,
    input  wire logic signed [COORD_WIDTH+4:0]     a1,
    input  wire logic signed [COORD_WIDTH+4:0]     a2,
    input  wire logic signed [COORD_WIDTH+4:0]     a3,
    output logic signed [COORD_WIDTH-1:0]          pos,
    output logic signed [COORD_WIDTH+2:0]          vel,
    output logic signed [COORD_WIDTH+4:0]          acc
);

    localparam int F   = T_FRAC_BITS;
    localparam int CFW = COORD_WIDTH + 5;
    localparam int UW  = T_FRAC_BITS + 1;
    localparam int VW  = COORD_WIDTH + 3;
    localparam int AW  = COORD_WIDTH + 5;
    localparam int PW  = CFW + UW;       // a3 * u
    localparam int HW  = PW + 1;         // a3 * u + a2 << F
    localparam int GW  = PW + 3;         // 3 a3 * u + 2 a2 << F, also 6 a3 * u
    localparam int SA  = HW / 2;
    localparam int SG  = GW / 2;
    localparam int HHW = HW - SA + UW + 1;
    localparam int HLW = SA + UW;
    localparam int GHW = GW - SG + UW + 1;
    localparam int GLW = SG + UW;
    localparam int GPW = GW + UW;
    localparam int H1W = HW + UW + 1;    // h2 * u + a1 << 2F
    localparam int S1  = H1W / 2;
    localparam int KHW = H1W - S1 + UW + 1;
    localparam int KLW = S1 + UW;
    localparam int FW  = H1W + UW;

    // Stage registers
    logic signed [PW-1:0]  p_reg, p_next;
    logic signed [HW-1:0]  h2_reg, h2_next;
    logic signed [GW-1:0]  g2_reg, g2_next;
    logic signed [GW-1:0]  s6;
    logic signed [HHW-1:0] hh_reg, hh_next;
    logic [HLW-1:0]        hl_reg, hl_next;
    logic signed [GHW-1:0] gh_reg, gh_next;
    logic [GLW-1:0]        gl_reg, gl_next;
    logic signed [H1W-1:0] h1_reg, h1_next;
    logic [GPW-1:0]        gsum;
    logic signed [KHW-1:0] kh_reg, kh_next;
    logic [KLW-1:0]        kl_reg, kl_next;
    logic [FW-1:0]         full;
    logic signed [COORD_WIDTH-1:0] pos_reg, pos_next;
    logic signed [VW-1:0]  vel_h1_reg, vel_p1_reg, vel_out_reg, vel_next;
    logic signed [AW-1:0]  acc_h2_reg, acc_p2_reg, acc_h1_reg, acc_p1_reg, acc_out_reg;
    logic signed [AW-1:0]  acc_next;

    // Multiply a3 by t
    always_comb
    begin
        p_next = PW'(a3 * $signed({1'b0, u_s0}));
    end

    // First Horner step for point and slope; finish second derivative
    always_comb
    begin
        h2_next  = HW'(p_reg) + (HW'(a2) <<< F);
        g2_next  = (GW'(p_reg) <<< 1) + GW'(p_reg) + (GW'(a2) <<< (F + 1));
        s6       = (GW'(p_reg) <<< 2) + (GW'(p_reg) <<< 1);
        acc_next = s6[F +: AW] + (a2 <<< 1);
    end

    // Split the wide multiplies by t into high and low partial products
    always_comb
    begin
        hh_next = HHW'($signed(h2_reg[HW-1:SA]) * $signed({1'b0, u_s2}));
        hl_next = HLW'(h2_reg[SA-1:0] * u_s2);
        gh_next = GHW'($signed(g2_reg[GW-1:SG]) * $signed({1'b0, u_s2}));
        gl_next = GLW'(g2_reg[SG-1:0] * u_s2);
    end

    // Merge partials; second Horner step and finished first derivative
    always_comb
    begin
        h1_next  = (H1W'(hh_reg) <<< SA) + H1W'(hl_reg) + (H1W'(a1) <<< (2 * F));
        gsum     = (GPW'(gh_reg) << SG) + GPW'(gl_reg);
        vel_next = gsum[2 * F +: VW] + a1[VW-1:0];
    end

    // Last multiply by t, split in two
    always_comb
    begin
        kh_next = KHW'($signed(h1_reg[H1W-1:S1]) * $signed({1'b0, u_s4}));
        kl_next = KLW'(h1_reg[S1-1:0] * u_s4);
    end

    // Merge partials and finish the curve point
    always_comb
    begin
        full     = (FW'(kh_reg) << S1) + FW'(kl_reg);
        pos_next = full[3 * F +: COORD_WIDTH] + a0[COORD_WIDTH-1:0];
    end

    // Advance each stage when the sequencer lets it load
    always_ff @(posedge clk)
    begin
        if (adv[cbe_pkg::STG_A3U])
        begin
            p_reg <= p_next;
        end
        if (adv[cbe_pkg::STG_H2])
        begin
            h2_reg     <= h2_next;
            g2_reg     <= g2_next;
            acc_h2_reg <= acc_next;
        end
        if (adv[cbe_pkg::STG_P2])
        begin
            hh_reg     <= hh_next;
            hl_reg     <= hl_next;
            gh_reg     <= gh_next;
            gl_reg     <= gl_next;
            acc_p2_reg <= acc_h2_reg;
        end
        if (adv[cbe_pkg::STG_H1])
        begin
            h1_reg     <= h1_next;
            vel_h1_reg <= vel_next;
            acc_h1_reg <= acc_p2_reg;
        end
        if (adv[cbe_pkg::STG_P1])
        begin
            kh_reg     <= kh_next;
            kl_reg     <= kl_next;
            vel_p1_reg <= vel_h1_reg;
            acc_p1_reg <= acc_h1_reg;
        end
        if (adv[cbe_pkg::STG_OUT])
        begin
            pos_reg     <= pos_next;
            vel_out_reg <= vel_p1_reg;
            acc_out_reg <= acc_p1_reg;
        end
    end

    assign pos = pos_reg;
    assign vel = vel_out_reg;
    assign acc = acc_out_reg;

endmodule

`default_nettype wire

// ----- rtl/cbe_pipe_ctrl.sv -----
`default_nettype none

// Valid bits and per-stage load enables; bubbles collapse under a stall.
module cbe_pipe_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           out_stall,
    output logic                in_stall,
    output cbe_pkg::pipe_ctl_t  ctl
);

    localparam int LAST = cbe_pkg::NUM_STAGES - 1;

    logic [cbe_pkg::NUM_STAGES-1:0] vld_reg, vld_next;
    logic [cbe_pkg::NUM_STAGES-1:0] adv;

    // A stage loads when it is empty or its successor loads
    always_comb
    begin
        adv[LAST] = !vld_reg[LAST] || !out_stall;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k + 1];
        end
    end

    // Move valid bits along with the data
    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k <= LAST; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall = !adv[0];
    assign ctl.adv  = adv;
    assign ctl.vld  = vld_reg;

endmodule

`default_nettype wire

// ----- rtl/cubic_bezier_evaluator_core.sv -----
// Throughput: one t per cycle while no output stall backs up to the input; the two-way
// split multiplies by t in the Horner stages set the stage depth.
// Reset: control points clear to zero and every pipeline stage empties.
// A stalled output holds; empty stages still fill behind it.
`default_nettype none

module cubic_bezier_evaluator_core #(
    parameter int COORD_WIDTH = cbe_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = cbe_pkg::T_FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [cbe_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [COORD_WIDTH-1:0]                cfg_data,
    // Curve parameter
    input  wire logic                                  param_valid,
    output logic                                       param_stall,
    input  wire logic [T_FRAC_BITS:0]                  param_t,
    // Results
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output logic signed [COORD_WIDTH-1:0]              pos_x,
    output logic signed [COORD_WIDTH-1:0]              pos_y,
    output logic signed [COORD_WIDTH+2:0]              vel_x,
    output logic signed [COORD_WIDTH+2:0]              vel_y,
    output logic signed [COORD_WIDTH+4:0]              acc_x,
    output logic signed [COORD_WIDTH+4:0]              acc_y
);

`include "cubic_bezier_evaluator_core_defines.svh"

    localparam int UW  = T_FRAC_BITS + 1;
    localparam int CFW = COORD_WIDTH + 5;
    localparam logic [UW-1:0] U_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam int UPIPE = cbe_pkg::STG_H1 + 1;

    logic signed [COORD_WIDTH-1:0] ctrl_reg [8];
    logic [UW-1:0]                 u_pipe_reg [UPIPE];
    logic [UW-1:0]                 u_clamped;
    cbe_pkg::pipe_ctl_t            ctl;
    logic signed [CFW-1:0]         ax0, ax1, ax2, ax3;
    logic signed [CFW-1:0]         ay0, ay1, ay2, ay3;

    // Control point registers; drop writes beyond the map
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                ctrl_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (cfg_index < cbe_pkg::CFG_NUM_REGS))
        begin
            ctrl_reg[cfg_index[cbe_pkg::CFG_SEL_WIDTH-1:0]] <= cfg_data;
        end
    end

    // Clamp t to one
    always_comb
    begin
        if (param_t[T_FRAC_BITS] && (|param_t[T_FRAC_BITS-1:0]))
        begin
            u_clamped = U_ONE;
        end
        else
        begin
            u_clamped = param_t;
        end
    end

    // Carry t down the stages that multiply by it
    always_ff @(posedge clk)
    begin
        if (ctl.adv[0])
        begin
            u_pipe_reg[0] <= u_clamped;
        end
        for (int k = 1; k < UPIPE; k++)
        begin
            if (ctl.adv[k])
            begin
                u_pipe_reg[k] <= u_pipe_reg[k - 1];
            end
        end
    end

    cbe_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (param_valid),
        .out_stall (result_stall),
        .in_stall  (param_stall),
        .ctl       (ctl)
    );

    cbe_coef #(.COORD_WIDTH(COORD_WIDTH)) u_coef_x (
        .clk (clk),
        .q0  (ctrl_reg[cbe_pkg::REG_P0_X]),
        .q1  (ctrl_reg[cbe_pkg::REG_P1_X]),
        .q2  (ctrl_reg[cbe_pkg::REG_P2_X]),
        .q3  (ctrl_reg[cbe_pkg::REG_P3_X]),
        .a0  (ax0),
        .a1  (ax1),
        .a2  (ax2),
        .a3  (ax3)
    );

    cbe_coef #(.COORD_WIDTH(COORD_WIDTH)) u_coef_y (
        .clk (clk),
        .q0  (ctrl_reg[cbe_pkg::REG_P0_Y]),
        .q1  (ctrl_reg[cbe_pkg::REG_P1_Y]),
        .q2  (ctrl_reg[cbe_pkg::REG_P2_Y]),
        .q3  (ctrl_reg[cbe_pkg::REG_P3_Y]),
        .a0  (ay0),
        .a1  (ay1),
        .a2  (ay2),
        .a3  (ay3)
    );

    cbe_axis #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_axis_x (
        .clk  (clk),
        .adv  (ctl.adv),
        .u_s0 (u_pipe_reg[cbe_pkg::STG_IN]),
        .u_s2 (u_pipe_reg[cbe_pkg::STG_H2]),
        .u_s4 (u_pipe_reg[cbe_pkg::STG_H1]),
        .a0   (ax0),
        .a1   (ax1),
        .a2   (ax2),
        .a3   (ax3),
        .pos  (pos_x),
        .vel  (vel_x),
        .acc  (acc_x)
    );

    cbe_axis #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_axis_y (
        .clk  (clk),
        .adv  (ctl.adv),
        .u_s0 (u_pipe_reg[cbe_pkg::STG_IN]),
        .u_s2 (u_pipe_reg[cbe_pkg::STG_H2]),
        .u_s4 (u_pipe_reg[cbe_pkg::STG_H1]),
        .a0   (ay0),
        .a1   (ay1),
        .a2   (ay2),
        .a3   (ay3),
        .pos  (pos_y),
        .vel  (vel_y),
        .acc  (acc_y)
    );

    assign result_valid = ctl.vld[cbe_pkg::STG_OUT];

    // Input stalls only when every stage holds an item
    `CBE_ASSERT_IMPLY(a_stall_full, clk, rst_n, param_stall, (&ctl.vld), "stall with a bubble")
    // An accepted t lands in the first stage
    `CBE_ASSERT_NEXT(a_accept_lands, clk, rst_n, (param_valid && !param_stall), ctl.vld[cbe_pkg::STG_IN], "accepted item lost")
    // A held middle stage keeps its item
    `CBE_ASSERT_NEXT(a_hold_mid, clk, rst_n, (ctl.vld[cbe_pkg::STG_P2] && !ctl.adv[cbe_pkg::STG_P2]), ctl.vld[cbe_pkg::STG_P2], "held item dropped")
    // Clamped t never exceeds one
    `CBE_ASSERT_IMPLY(a_t_clamped, clk, rst_n, ctl.vld[cbe_pkg::STG_IN], (u_pipe_reg[cbe_pkg::STG_IN] <= U_ONE), "t above one")

endmodule

`default_nettype wire

// ----- test/tb_cubic_bezier_evaluator_core.sv -----
`default_nettype none

module tb_cubic_bezier_evaluator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = cbe_pkg::COORD_WIDTH_DEF;
    localparam int TF = cbe_pkg::T_FRAC_BITS_DEF;
    localparam logic [TF:0] T_ONE = {1'b1, {TF{1'b0}}};
    localparam logic [TF:0] T_ALL = '1;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW+2:0] vel_x;
        logic signed [CW+2:0] vel_y;
        logic signed [CW+4:0] acc_x;
        logic signed [CW+4:0] acc_y;
    } curve_sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [cbe_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;
    logic param_valid = 1'b0;
    logic param_stall;
    logic [TF:0] param_t = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW+2:0] vel_x;
    logic signed [CW+2:0] vel_y;
    logic signed [CW+4:0] acc_x;
    logic signed [CW+4:0] acc_y;

    // Control points as the block should hold them
    logic signed [CW-1:0] ctrl_pts [8];
    curve_sample_t pending_samples [$];
    int mismatch_count = 0;
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    bit hold_req = 1'b0;

    cubic_bezier_evaluator_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .param_valid(param_valid),
        .param_stall(param_stall),
        .param_t(param_t),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .vel_x(vel_x),
        .vel_y(vel_y),
        .acc_x(acc_x),
        .acc_y(acc_y)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Evaluate one axis exactly, then floor to whole coordinate units
    function automatic void eval_axis(input logic signed [CW-1:0] q0, q1, q2, q3,
                                      input logic [TF:0] tc,
                                      output logic signed [CW-1:0] p,
                                      output logic signed [CW+2:0] v,
                                      output logic signed [CW+4:0] a);
        logic signed [127:0] u, k0, a1, a2, a3, pos_n, vel_n, acc_n;
        u = 128'(tc);
        k0 = 128'(q0);
        a1 = 3 * (k0 - q1) * -1;
        a2 = 3 * (k0 - 2 * q1 + q2);
        a3 = q3 - k0 + 3 * (q1 - q2);
        pos_n = (k0 <<< (3 * TF)) + ((a1 * u) <<< (2 * TF))
              + ((a2 * u * u) <<< TF) + a3 * u * u * u;
        vel_n = (a1 <<< (2 * TF)) + ((2 * a2 * u) <<< TF) + 3 * a3 * u * u;
        acc_n = ((2 * a2) <<< TF) + 6 * a3 * u;
        p = CW'(pos_n >>> (3 * TF));
        v = (CW+3)'(vel_n >>> (2 * TF));
        a = (CW+5)'(acc_n >>> TF);
    endfunction

    // Clamp t to one and evaluate both axes
    function automatic curve_sample_t eval_curve(input logic [TF:0] t);
        curve_sample_t s;
        logic [TF:0] tc;
        logic signed [CW-1:0] px, py;
        logic signed [CW+2:0] vx, vy;
        logic signed [CW+4:0] ax, ay;
        tc = (t > T_ONE) ? T_ONE : t;
        eval_axis(ctrl_pts[cbe_pkg::REG_P0_X], ctrl_pts[cbe_pkg::REG_P1_X],
                  ctrl_pts[cbe_pkg::REG_P2_X], ctrl_pts[cbe_pkg::REG_P3_X],
                  tc, px, vx, ax);
        eval_axis(ctrl_pts[cbe_pkg::REG_P0_Y], ctrl_pts[cbe_pkg::REG_P1_Y],
                  ctrl_pts[cbe_pkg::REG_P2_Y], ctrl_pts[cbe_pkg::REG_P3_Y],
                  tc, py, vy, ay);
        s.pos_x = px;
        s.pos_y = py;
        s.vel_x = vx;
        s.vel_y = vy;
        s.acc_x = ax;
        s.acc_y = ay;
        return s;
    endfunction

    // Mostly short idle stretches, a few long ones
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TF:0] rand_t();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return (TF+1)'($urandom_range(0, T_ONE));
        if (r < 8)
            return (TF+1)'($urandom);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return (TF+1)'(1);
            2: return (TF+1)'(T_ONE - 1);
            3: return T_ONE;
            4: return (TF+1)'(T_ONE + 1);
            default: return T_ALL;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2, 3: return CW'($urandom_range(0, 4095) - 2048);
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Hold the write until the block takes it; leave valid high for the caller
    task automatic write_reg(input logic [cbe_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx < cbe_pkg::CFG_NUM_REGS)
            ctrl_pts[idx[cbe_pkg::CFG_SEL_WIDTH-1:0]] = data;
    endtask

    // Load all four points, then scatter writes to unmapped indexes
    task automatic load_points(input logic signed [CW-1:0] pts [8], input int n_unmapped);
        for (int i = 0; i < cbe_pkg::CFG_NUM_REGS; i++)
            write_reg(cbe_pkg::CFG_INDEX_WIDTH'(i), pts[i]);
        for (int i = 0; i < n_unmapped; i++)
            write_reg(cbe_pkg::CFG_NUM_REGS
                      + cbe_pkg::CFG_INDEX_WIDTH'($urandom_range(0, 7)), CW'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Offer one t until transferred, then idle if asked
    task automatic send_t(input logic [TF:0] t);
        int gap;
        param_valid <= 1'b1;
        param_t <= t;
        do @(posedge clk); while (param_stall);
        pending_samples.push_back(eval_curve(t));
        gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap > 0)
        begin
            param_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait for the pipeline to empty
    task automatic drain_pipe();
        param_valid <= 1'b0;
        while (pending_samples.size() > 0)
            @(posedge clk);
        repeat (cbe_pkg::NUM_STAGES + 2) @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_t('0);
        send_t(T_ONE);
        send_t(T_ALL);
        drain_pipe();
    endtask

    task automatic test_directed();
        logic signed [CW-1:0] pts [8];
        // Alternate extremes so every coefficient reaches its largest magnitude
        pts = '{C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX};
        load_points(pts, 2);
        send_t('0);
        send_t((TF+1)'(1));
        send_t(T_ONE >> 1);
        send_t((TF+1)'(T_ONE - 1));
        send_t(T_ONE);
        send_t((TF+1)'(T_ONE + 1));
        send_t(T_ALL);
        drain_pipe();
        pts = '{default: C_MAX};
        load_points(pts, 0);
        send_t('0);
        send_t(17'h0AAAA);
        send_t(T_ONE);
        drain_pipe();
        pts = '{default: C_MIN};
        load_points(pts, 1);
        send_t(17'h05555);
        send_t(17'h15555);
        drain_pipe();
        // Tiny inner points: results just below zero must floor to -1 LSB
        pts = '{CW'(0), CW'(0), CW'(1), -CW'(1), CW'(1), -CW'(1), CW'(0), CW'(0)};
        load_points(pts, 0);
        send_t((TF+1)'(1));
        send_t((TF+1)'(2));
        send_t((TF+1)'(T_ONE - 1));
        drain_pipe();
    endtask

    task automatic test_random_curves();
        logic signed [CW-1:0] pts [8];
        for (int set_i = 0; set_i < 12; set_i++)
        begin
            foreach (pts[i])
                pts[i] = rand_coord();
            load_points(pts, $urandom_range(0, 2));
            // One set in four runs with no idling on either side
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = tx_idle_on;
            repeat (50) send_t(rand_t());
            drain_pipe();
        end
    endtask

    task automatic test_backpressure();
        logic signed [CW-1:0] pts [8];
        foreach (pts[i])
            pts[i] = rand_coord();
        load_points(pts, 0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (60) send_t(rand_t());
        drain_pipe();
    endtask

    // Receiver: long hold on request, otherwise random stalls
    initial
    begin : drive_result_stall
        int hold_cnt;
        int stall_left;
        hold_cnt = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                hold_cnt++;
                if (hold_cnt >= HOLD_CYCLES)
                begin
                    hold_req = 1'b0;
                    hold_cnt = 0;
                end
            end
            else if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 99) < 25)
            begin
                result_stall <= 1'b1;
                stall_left = idle_len() - 1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Compare each result transfer with the oldest expected sample
    always @(posedge clk)
    begin : check_results
        curve_sample_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                $display("%0t: result transfer with no sample expected", $time);
                mismatch_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                check_field("pos_x", longint'(want.pos_x), longint'(pos_x));
                check_field("pos_y", longint'(want.pos_y), longint'(pos_y));
                check_field("vel_x", longint'(want.vel_x), longint'(vel_x));
                check_field("vel_y", longint'(want.vel_y), longint'(vel_y));
                check_field("acc_x", longint'(want.acc_x), longint'(acc_x));
                check_field("acc_y", longint'(want.acc_y), longint'(acc_y));
            end
        end
    end

    // End the run if no transfer happens for too long
    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if ((param_valid && !param_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog timeout", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        foreach (ctrl_pts[i])
            ctrl_pts[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed();
        test_random_curves();
        test_backpressure();
        drain_pipe();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/cbe_pkg.sv
rtl/cbe_coef.sv
rtl/cbe_axis.sv
rtl/cbe_pipe_ctrl.sv
rtl/cubic_bezier_evaluator_core.sv
test/tb_cubic_bezier_evaluator_core.sv
